// File: src/sc2c_pkg.sv
package sc2c_pkg;

   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_SET  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [31:0] RESET_COUNT   = 32'd662774400;
   localparam logic [17:0] SECS_PER_DAY  = 18'd86400;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [11:0] SECS_PER_MIN  = 12'd60;
   localparam logic [11:0] BASE_YEAR     = 12'd2000;
   localparam logic [3:0]  BASE_WEEKDAY  = 4'd5;
   localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
   localparam logic [3:0]  LAST_MONTH    = 4'd11;
   localparam logic [7:0]  CENTURY_OFF   = 8'd100;

   // Rounded-up reciprocals for exact division by multiply and shift. The day
   // divide works on the count over 128 (86400 = 128 * 675) with a shift of 35,
   // the hour divide on seconds over 16 (3600 = 16 * 225) with a shift of 21,
   // the minute divide on seconds over 4 (60 = 4 * 15) with a shift of 14 and
   // the weekday divide by 7 with a shift of 19.
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam logic [10:0] MIN_RECIP  = 11'd1093;
   localparam logic [16:0] WEEK_RECIP = 17'd74899;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] new_time;
   } req_word_type;

   typedef struct packed {
      logic [31:0] timestamp;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic days_step;
      logic tod_step;
      logic wday_step;
      logic year_step;
      logic month_step;
      logic hour_step;
      logic hrem_step;
      logic min_step;
      logic mrem_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
      logic out_free;
   } status_type;

   // Year is kept as an offset from 2000; within 2000..2136 only 2100 breaks the
   // divisible-by-four rule.
   function automatic logic leap_year(input logic [7:0] yoff);
      leap_year = (yoff[1:0] == 2'd0) && (yoff != CENTURY_OFF);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      case (mon)
         4'd1:                   len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:                len = 5'd31;
      endcase
      month_len = len;
   endfunction

endpackage

// File: src/sc2c_ctrl.sv
module sc2c_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sc2c_pkg::status_type   status,
   output sc2c_pkg::cmd_type      cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DAYS  = 4'd1;
   localparam logic [3:0] ST_TOD   = 4'd2;
   localparam logic [3:0] ST_WDAY  = 4'd3;
   localparam logic [3:0] ST_YEAR  = 4'd4;
   localparam logic [3:0] ST_MONTH = 4'd5;
   localparam logic [3:0] ST_HOUR  = 4'd6;
   localparam logic [3:0] ST_HREM  = 4'd7;
   localparam logic [3:0] ST_MIN   = 4'd8;
   localparam logic [3:0] ST_MREM  = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DAYS;
            end
         end
         ST_DAYS: begin
            cmd.days_step = 1'b1;
            state_in      = ST_TOD;
         end
         ST_TOD: begin
            cmd.tod_step = 1'b1;
            state_in     = ST_WDAY;
         end
         ST_WDAY: begin
            cmd.wday_step = 1'b1;
            state_in      = ST_YEAR;
         end
         ST_YEAR: begin
            cmd.year_step = 1'b1;
            if (status.year_done) begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            cmd.month_step = 1'b1;
            if (status.month_done) begin
               state_in = ST_HOUR;
            end
         end
         ST_HOUR: begin
            cmd.hour_step = 1'b1;
            state_in      = ST_HREM;
         end
         ST_HREM: begin
            cmd.hrem_step = 1'b1;
            state_in      = ST_MIN;
         end
         ST_MIN: begin
            cmd.min_step = 1'b1;
            state_in     = ST_MREM;
         end
         ST_MREM: begin
            cmd.mrem_step = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/sc2c_datapath.sv
module sc2c_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  sc2c_pkg::cmd_type       cmd,
   output sc2c_pkg::status_type    status,
   input  sc2c_pkg::req_word_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sc2c_pkg::rsp_word_type  rsp_data
);

   logic [31:0] count_ff, count_in;
   logic [14:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [2:0]  wk_ff, wk_in;
   logic [15:0] days_ff, days_in;
   logic [7:0]  yoff_ff, yoff_in;
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sc2c_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic [50:0] day_prod;
   logic [31:0] day_secs;
   logic [31:0] tod_full;
   logic [16:0] wk_base;
   logic [33:0] wk_prod;
   logic [16:0] wk_mul;
   logic [16:0] wk_diff;
   logic [8:0]  ylen;
   logic        leap;
   logic [4:0]  mlen;
   logic [26:0] hr_prod;
   logic [16:0] hr_secs;
   logic [20:0] mn_prod;
   logic [11:0] mn_secs;

   assign leap = sc2c_pkg::leap_year(yoff_ff);
   assign ylen = leap ? 9'd366 : 9'd365;
   assign mlen = sc2c_pkg::month_len(mon_ff, leap);

   assign status.year_done  = (days_ff < {7'd0, ylen});
   assign status.month_done = (mon_ff == sc2c_pkg::LAST_MONTH) || (days_ff < {11'd0, mlen});
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // Each quotient is taken in one state and its remainder in the state after it, so
   // that no multiply feeds another in the same cycle.
   assign day_prod = {26'd0, count_ff[31:7]} * {25'd0, sc2c_pkg::DAY_RECIP};
   assign day_secs = {16'd0, days_ff} * {14'd0, sc2c_pkg::SECS_PER_DAY};
   assign tod_full = count_ff - day_secs;

   assign wk_base = {1'b0, days_ff} + {13'd0, sc2c_pkg::BASE_WEEKDAY};
   assign wk_prod = {17'd0, wk_base} * {17'd0, sc2c_pkg::WEEK_RECIP};
   assign wk_mul  = {2'd0, quot_ff} * {14'd0, sc2c_pkg::DAYS_PER_WEEK};
   assign wk_diff = wk_base - wk_mul;

   assign hr_prod = {14'd0, rem_ff[16:4]} * {13'd0, sc2c_pkg::HOUR_RECIP};
   assign hr_secs = {12'd0, hour_ff} * sc2c_pkg::SECS_PER_HOUR;
   assign mn_prod = {11'd0, rem_ff[11:2]} * {10'd0, sc2c_pkg::MIN_RECIP};
   assign mn_secs = {6'd0, min_ff} * sc2c_pkg::SECS_PER_MIN;

   always_comb begin
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      wk_in    = wk_ff;
      days_in  = days_ff;
      yoff_in  = yoff_ff;
      mon_in   = mon_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;

      if (cmd.load) begin
         case (req_data.req_type)
            sc2c_pkg::REQ_TICK: count_in = count_ff + 32'd1;
            sc2c_pkg::REQ_SET:  count_in = req_data.new_time;
            default:            count_in = count_ff;
         endcase
         yoff_in = 8'd0;
         mon_in  = 4'd0;
      end

      if (cmd.days_step) begin
         days_in = day_prod[50:35];
      end

      // The weekday quotient is taken here while the day count is still whole.
      if (cmd.tod_step) begin
         rem_in  = tod_full[16:0];
         quot_in = wk_prod[33:19];
      end

      if (cmd.wday_step) begin
         wk_in = wk_diff[2:0];
      end

      if (cmd.year_step && !status.year_done) begin
         days_in = days_ff - {7'd0, ylen};
         yoff_in = yoff_ff + 8'd1;
      end

      if (cmd.month_step && !status.month_done) begin
         days_in = days_ff - {11'd0, mlen};
         mon_in  = mon_ff + 4'd1;
      end

      if (cmd.hour_step) begin
         hour_in = hr_prod[25:21];
      end

      if (cmd.hrem_step) begin
         rem_in = rem_ff - hr_secs;
      end

      if (cmd.min_step) begin
         min_in = mn_prod[19:14];
      end

      if (cmd.mrem_step) begin
         rem_in = {5'd0, rem_ff[11:0] - mn_secs};
      end
   end

   always_comb begin
      rsp_data_in           = rsp_data_ff;
      rsp_valid_in          = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.timestamp = count_ff;
         rsp_data_in.year      = sc2c_pkg::BASE_YEAR + {4'd0, yoff_ff};
         rsp_data_in.month     = mon_ff + 4'd1;
         rsp_data_in.day       = days_ff[4:0] + 5'd1;
         rsp_data_in.hour      = hour_ff;
         rsp_data_in.minute    = min_ff;
         rsp_data_in.second    = rem_ff[5:0];
         rsp_data_in.weekday   = wk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= sc2c_pkg::RESET_COUNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      wk_ff       <= wk_in;
      days_ff     <= days_in;
      yoff_ff     <= yoff_in;
      mon_ff      <= mon_in;
      hour_ff     <= hour_in;
      min_ff      <= min_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/seconds_counter_to_calendar_unit.sv
// From an accepted word to its result the unit takes the day count, time of day
// and weekday, walks the whole years since 2000 (0..136) and then the months
// passed in the year (0..11) one step at a time, then the hour, minute and seconds.
// One word at a time: a new word is taken only once the last result is loaded,
// and that load waits for the previous result to leave.
// Reset: synchronous, active high; the count restarts at 2021-01-01 00:00:00.
module seconds_counter_to_calendar_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sc2c_pkg::req_word_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sc2c_pkg::rsp_word_type  rsp_data
);

   sc2c_pkg::cmd_type    cmd;
   sc2c_pkg::status_type status;

   sc2c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sc2c_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
